### src/ckt_pkg.sv
// Shared types and constants for the coordinate keyed table.
// Holds the table size, operation and result codes, and the command and
// status structs that join the controller to the datapath.
package ckt_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int MARKS_W  = 32;
  localparam int ENTRY_W  = KEY_W + MARKS_W;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 4;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 40;

  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEWEST     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_KEY    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_NEWEST = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_NEXT,
    RD_NEWEST
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_UPDATE,
    WR_APPEND,
    WR_SHIFT
  } wr_sel_t;

  typedef struct packed {
    logic              load_item;
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic              wr_en;
    wr_sel_t           wr_sel;
    logic              idx_inc;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_set;
    logic              res_hit;
    logic [STAT_W-1:0] res_status;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_zero;
    logic              cnt_full;
    logic              idx_last;
    logic              key_match;
    logic              out_busy;
  } sts_t;

endpackage

### src/ckt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stands alone; width and depth come from its parameters.
module ckt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/ckt_datapath.sv
// Datapath of the coordinate keyed table: captured item, entry RAM, walk
// index, entry count, result flags and the output register.
// Depends on ckt_pkg and ckt_ram.
module ckt_datapath
  import ckt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [MARKS_W-1:0]  in_marks,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_found,
  output logic [MARKS_W-1:0]  out_marks,
  output logic [STAT_W-1:0]   out_status,
  output logic [COUNT_W-1:0]  out_count
);

  logic [MODE_W-1:0]  mode_r;
  logic [KEY_W-1:0]   key_r;
  logic [MARKS_W-1:0] marks_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               res_hit_r;
  logic [STAT_W-1:0]  res_status_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [MARKS_W-1:0] out_marks_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    raddr = idx_r;
      RD_NEXT:   raddr = IDX_W'(idx_r + IDX_W'(1));
      RD_NEWEST: raddr = IDX_W'(count_r - CNT_W'(1));
      default:   raddr = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_UPDATE: begin
        waddr = idx_r;
        wdata = {marks_r, key_r};
      end
      WR_APPEND: begin
        waddr = IDX_W'(count_r);
        wdata = {marks_r, key_r};
      end
      WR_SHIFT: begin
        waddr = idx_r;
        wdata = rdata;
      end
      default: begin
        waddr = idx_r;
        wdata = {marks_r, key_r};
      end
    endcase
  end

  ckt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_item) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = IDX_W'(idx_r + IDX_W'(1));
    end
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = CNT_W'(count_r + CNT_W'(1));
    end else if (cmd.cnt_dec) begin
      count_nxt = CNT_W'(count_r - CNT_W'(1));
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_item) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      marks_r <= in_marks;
    end
    if (cmd.res_set) begin
      res_hit_r    <= cmd.res_hit;
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_found_r  <= res_hit_r;
      out_marks_r  <= res_hit_r ? rdata[ENTRY_W-1:KEY_W] : '0;
      out_status_r <= res_status_r;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  assign sts.mode      = mode_r;
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.cnt_full  = (count_r == CNT_W'(CAPACITY));
  assign sts.idx_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.key_match = (rdata[KEY_W-1:0] == key_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_marks  = out_marks_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

### src/ckt_ctrl.sv
// Controller of the coordinate keyed table: walks the entries for a key,
// drives updates, appends and the shift that closes a gap after a delete.
// Depends on ckt_pkg; talks to ckt_datapath through cmd_t and sts_t.
module ckt_ctrl
  import ckt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    logic miss;
    miss      = 1'b0;
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_INSERT, MODE_LOOKUP, MODE_DEL_KEY: begin
            if (sts.cnt_zero) begin
              miss = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_IDX;
              state_nxt  = S_SCAN;
            end
          end
          MODE_NEWEST: begin
            cmd.res_set = 1'b1;
            if (sts.cnt_zero) begin
              cmd.res_status = STAT_EMPTY;
            end else begin
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_NEWEST;
              cmd.res_hit    = 1'b1;
              cmd.res_status = STAT_OK;
            end
            state_nxt = S_RESULT;
          end
          MODE_DEL_NEWEST: begin
            cmd.res_set = 1'b1;
            if (sts.cnt_zero) begin
              cmd.res_status = STAT_EMPTY;
            end else begin
              cmd.cnt_dec    = 1'b1;
              cmd.res_status = STAT_OK;
            end
            state_nxt = S_RESULT;
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = STAT_OK;
            state_nxt      = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.key_match) begin
          case (sts.mode)
            MODE_INSERT: begin
              cmd.wr_en      = 1'b1;
              cmd.wr_sel     = WR_UPDATE;
              cmd.res_set    = 1'b1;
              cmd.res_status = STAT_OK;
              state_nxt      = S_RESULT;
            end
            MODE_LOOKUP: begin
              cmd.res_set    = 1'b1;
              cmd.res_hit    = 1'b1;
              cmd.res_status = STAT_OK;
              state_nxt      = S_RESULT;
            end
            default: begin
              state_nxt = S_SHIFT_CHK;
            end
          endcase
        end else if (sts.idx_last) begin
          miss = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT_CHK: begin
        if (sts.idx_last) begin
          cmd.cnt_dec    = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = STAT_OK;
          state_nxt      = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_SHIFT_CHK;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The key is absent: an insert appends when there is room.
    if (miss) begin
      cmd.res_set = 1'b1;
      state_nxt   = S_RESULT;
      if (sts.mode == MODE_INSERT) begin
        if (sts.cnt_full) begin
          cmd.res_status = STAT_FULL;
        end else begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_APPEND;
          cmd.cnt_inc    = 1'b1;
          cmd.res_status = STAT_OK;
        end
      end else begin
        cmd.res_status = STAT_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = rst_n && (state_r == S_IDLE);

endmodule

### src/coordinate_keyed_table_top.sv
// Top level of the coordinate keyed table: stream ports, controller and
// datapath. Depends on ckt_pkg, ckt_ctrl, ckt_datapath and ckt_ram.
//
// The table holds up to CAPACITY entries in insertion order, each a signed
// (x,y) key with four 8-bit marks, and handles one operation per input beat
// with exactly one result beat. Items are taken one at a time. The entries
// sit in a RAM with one read and one write port that is walked one entry per
// cycle: an item is taken in the idle state and decoded; an insert, lookup or
// delete by key then compares entries until the key is found or the walk ends,
// and a delete by key moves each later entry down one place. A finished result
// waits in an output register, so a stalled result port holds the next item
// only in its result state.
module coordinate_keyed_table_top
  import ckt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // mode[2:0], key_x[10:3], key_y[18:11], mark_north[26:19],
  // mark_east[34:27], mark_south[42:35], mark_west[50:43], zeros above.
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // found[0], out_north[8:1], out_east[16:9], out_south[24:17],
  // out_west[32:25], status[34:33], entry_count[38:35], zero at 39.
  output logic [OUT_W-1:0] out_tdata
);

  cmd_t               cmd;
  sts_t               sts;
  logic [KEY_W-1:0]   in_key;
  logic [MARKS_W-1:0] in_marks;
  logic               res_found;
  logic [MARKS_W-1:0] res_marks;
  logic [STAT_W-1:0]  res_status;
  logic [COUNT_W-1:0] res_count;

  // Key is x over y; marks are north in the low byte up to west on top.
  assign in_key   = {in_tdata[10:3], in_tdata[18:11]};
  assign in_marks = in_tdata[50:19];

  ckt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ckt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tdata[2:0]),
    .in_key     (in_key),
    .in_marks   (in_marks),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_found  (res_found),
    .out_marks  (res_marks),
    .out_status (res_status),
    .out_count  (res_count)
  );

  assign out_tdata = {1'b0, res_count, res_status, res_marks, res_found};

endmodule
